### design/pli_pkg.sv
// Package for the positional list core: codes, field widths and the cell control word.
package pli_pkg;

  // Input and output word field widths
  localparam int unsigned PosW   = 8;
  localparam int unsigned ValW   = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  // Operation kinds carried in tuser
  localparam logic [KindW-1:0] KindIns  = 2'd0;
  localparam logic [KindW-1:0] KindDel  = 2'd1;
  localparam logic [KindW-1:0] KindDump = 2'd2;

  // Result status codes
  localparam logic [StatW-1:0] StatOk    = 2'd0;
  localparam logic [StatW-1:0] StatRange = 2'd1;
  localparam logic [StatW-1:0] StatFull  = 2'd2;
  localparam logic [StatW-1:0] StatEmpty = 2'd3;

  // Operation that every cell applies at a clock edge
  typedef enum logic [1:0] {
    CellHold,
    CellIns,
    CellDel,
    CellRot
  } cell_op_e;

  // Control word broadcast along the chain
  typedef struct packed {
    cell_op_e        op;
    logic [PosW-1:0] idx;    // zero-based target index for insert and delete
    logic [PosW-1:0] tail;   // index of the last held entry, for rotation
    logic [ValW-1:0] value;  // value written at idx on insert
  } cell_ctrl_t;

endpackage

### design/pli_cell.sv
// One storage cell of the list chain: holds one entry and trades it with its neighbors.
module pli_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                      clk_i,
  input  pli_pkg::cell_ctrl_t       ctrl_i,
  input  logic [pli_pkg::ValW-1:0]  left_i,   // entry of the cell one index lower
  input  logic [pli_pkg::ValW-1:0]  right_i,  // entry of the cell one index higher
  input  logic [pli_pkg::ValW-1:0]  head_i,   // entry of cell 0, wraps in on rotation
  output logic [pli_pkg::ValW-1:0]  data_o
);
  import pli_pkg::*;

  localparam logic [PosW-1:0] MyIdx = PosW'(IDX);

  logic [ValW-1:0] data_q, data_d;

  // Next entry from the broadcast operation
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CellIns: begin
        if (MyIdx > ctrl_i.idx) begin
          data_d = left_i;
        end else if (MyIdx == ctrl_i.idx) begin
          data_d = ctrl_i.value;
        end
      end
      CellDel: begin
        if (MyIdx >= ctrl_i.idx) begin
          data_d = right_i;
        end
      end
      CellRot: begin
        if (MyIdx == ctrl_i.tail) begin
          data_d = head_i;
        end else if (MyIdx < ctrl_i.tail) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### design/positional_list_insert_delete_core.sv
// Top level of the positional list core: handshake, status decode and the cell chain.
//
// Usage: items enter on the s_axis channel. tuser carries the kind (insert,
// delete, dump), tdata the 1-based position and the value. Results leave on
// the m_axis channel: tuser is the status, tdata the entry value and the
// entry count held afterwards, tlast marks the final word of an item.
// Insert and delete shift the whole chain of cells at once, so such an
// item's single result word is written into the output register at the
// edge that takes the item; one item per cycle is sustained while
// the receiver keeps tready high.
// A dump of N entries rotates the chain once per word: the accept edge
// moves the sequencer into its dump state, which registers the first word;
// then one word per cycle follows while tready stays high, N words in all; no
// new item is taken meanwhile.
// The chain ends up in its original order when the last word is sent.
// When the receiver stalls, the output register holds its word and the
// block takes no further item until that word is gone.
// Reset clears the entry count, the output valid flag and the dump
// sequencer; entry contents are left as they are and are never read
// before being written.
module positional_list_insert_delete_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // position[7:0], value[39:8]
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // entry_value[31:0], entry_count[36:32], zero[39:37]
  output logic [1:0]  m_axis_tuser_o,   // status[1:0]
  output logic        m_axis_tlast_o
);
  import pli_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  localparam logic StIdle = 1'b0;
  localparam logic StDump = 1'b1;

  // Input word fields
  logic [KindW-1:0] kind;
  logic [PosW-1:0]  pos;
  logic [ValW-1:0]  value;
  assign kind  = s_axis_tuser_i;
  assign pos   = s_axis_tdata_i[PosW-1:0];
  assign value = s_axis_tdata_i[PosW+ValW-1:PosW];

  logic            state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   dcnt_q, dcnt_d;
  logic            out_valid_q, out_valid_d;
  logic [StatW-1:0] out_stat_q, out_stat_d;
  logic [ValW-1:0] out_val_q, out_val_d;
  logic [CW-1:0]   out_cnt_q, out_cnt_d;
  logic            out_last_q, out_last_d;

  logic            out_free, s_acc;
  logic [PosW:0]   pos_x, cnt_x;
  logic [CW-1:0]   tail_c;
  logic            ins_ok;
  cell_ctrl_t      ctrl;
  logic [ValW-1:0] cell_data [CAPACITY];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle) && out_free;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign pos_x           = {1'b0, pos};
  assign cnt_x           = (PosW+1)'(cnt_q);
  assign tail_c          = cnt_q - CW'(1);
  assign ins_ok          = s_acc && (kind == KindIns) && (pos != '0) &&
                           (pos_x <= cnt_x + (PosW+1)'(1)) && (cnt_q != CW'(CAPACITY));

  // Decode, status and sequencing
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_stat_d  = out_stat_q;
    out_val_d   = out_val_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    ctrl.op     = CellHold;
    ctrl.idx    = pos - PosW'(1);
    ctrl.tail   = PosW'(tail_c);
    ctrl.value  = value;

    unique case (state_q)
      StIdle: begin
        if (s_acc) begin
          out_valid_d = 1'b1;
          out_stat_d  = StatOk;
          out_val_d   = '0;
          out_last_d  = 1'b1;
          unique case (kind)
            KindIns: begin
              if (pos == '0 || pos_x > cnt_x + (PosW+1)'(1)) begin
                out_stat_d = StatRange;
              end else if (cnt_q == CW'(CAPACITY)) begin
                out_stat_d = StatFull;
              end else begin
                ctrl.op = CellIns;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            KindDel: begin
              if (cnt_q == '0) begin
                out_stat_d = StatEmpty;
              end else if (pos == '0 || pos_x > cnt_x) begin
                out_stat_d = StatRange;
              end else begin
                ctrl.op = CellDel;
                cnt_d   = cnt_q - CW'(1);
              end
            end
            KindDump: begin
              if (cnt_q == '0) begin
                out_stat_d = StatEmpty;
              end else begin
                // words come from the dump sequencer
                out_valid_d = 1'b0;
                state_d     = StDump;
                dcnt_d      = '0;
              end
            end
            default: out_stat_d = StatOk;
          endcase
          out_cnt_d = cnt_d;
        end
      end
      StDump: begin
        // one word per cycle, while the output register is free, from the head of the rotating chain
        if (out_free) begin
          ctrl.op     = CellRot;
          out_valid_d = 1'b1;
          out_stat_d  = StatOk;
          out_val_d   = cell_data[0];
          out_cnt_d   = cnt_q;
          out_last_d  = (dcnt_q == tail_c[IW-1:0]);
          dcnt_d      = dcnt_q + IW'(1);
          if (dcnt_q == tail_c[IW-1:0]) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    out_stat_q <= out_stat_d;
    out_val_q  <= out_val_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ValW-1:0] left_c, right_c;
    if (i == 0) begin : g_first
      assign left_c = cell_data[i];
    end else begin : g_mid_l
      assign left_c = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_c = cell_data[i];
    end else begin : g_mid_r
      assign right_c = cell_data[i+1];
    end
    pli_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left_c),
      .right_i(right_c),
      .head_i (cell_data[0]),
      .data_o (cell_data[i])
    );
  end

  // Output word, count masked to the field width
  logic [CW+CountW-1:0] cnt_wide;
  assign cnt_wide        = {{CountW{1'b0}}, out_cnt_q};
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {3'b000, cnt_wide[CountW-1:0], out_val_q};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDump) |-> !s_axis_tready_o)
    else $error("item taken during dump");

  a_dump_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDump) |-> ((CW)'(dcnt_q) < cnt_q))
    else $error("dump index beyond held entries");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_ok |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not grow the count");
`endif

endmodule

### tb/sv/tb_positional_list_insert_delete_core.sv
// Self-checking testbench for the positional list core: directed corner items, then random mixes.
module tb_positional_list_insert_delete_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pli_pkg::*;

  localparam int unsigned Capacity = 16;
  // Kind 3 has no operation; the block answers it with a plain ok word
  localparam logic [KindW-1:0] KindSpare = 2'd3;

  // One expected output word
  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [ValW-1:0]   value;
    logic [CountW-1:0] count;
    logic              last;
  } list_word_t;

  typedef enum int {ModeGrow, ModeShrink, ModeMixed} mix_e;

  // List predictor plus the queue of words still owed by the block
  class list_scoreboard;
    int unsigned cap;
    logic [ValW-1:0] entries[$];
    list_word_t owed_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned full_hits;
    int unsigned dumps;
    int unsigned peak_fill;
    int unsigned status_tally[4];

    function new(int unsigned cap_i);
      cap = cap_i;
    endfunction

    function int unsigned size();
      return entries.size();
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void owe(logic [StatW-1:0] st, logic [ValW-1:0] val, logic lst);
      list_word_t w;
      w.status = st;
      w.value  = val;
      w.count  = CountW'(entries.size());
      w.last   = lst;
      owed_q.push_back(w);
    endfunction

    // Apply one accepted item to the list and queue the words it causes
    function void note_item(logic [KindW-1:0] k, logic [PosW-1:0] p, logic [ValW-1:0] v);
      int unsigned n;
      int unsigned pos;
      n = entries.size();
      pos = 32'(p);
      case (k)
        KindIns: begin
          if (pos == 0 || pos > n + 1) begin
            owe(StatRange, '0, 1'b1);
          end else if (n >= cap) begin
            full_hits++;
            owe(StatFull, '0, 1'b1);
          end else begin
            entries.insert(pos - 1, v);
            owe(StatOk, '0, 1'b1);
          end
        end
        KindDel: begin
          if (n == 0) begin
            owe(StatEmpty, '0, 1'b1);
          end else if (pos == 0 || pos > n) begin
            owe(StatRange, '0, 1'b1);
          end else begin
            entries.delete(pos - 1);
            owe(StatOk, '0, 1'b1);
          end
        end
        KindDump: begin
          if (n == 0) begin
            owe(StatEmpty, '0, 1'b1);
          end else begin
            dumps++;
            for (int i = 0; i < n; i++) owe(StatOk, entries[i], i == n - 1);
          end
        end
        default: owe(StatOk, '0, 1'b1);
      endcase
      if (entries.size() > peak_fill) peak_fill = entries.size();
    endfunction

    task report_mismatch(string what);
      $display("ERROR @%0t: %s", $time, what);
      errors++;
    endtask

    // Compare one accepted output word with the oldest owed word
    task check_word(logic [StatW-1:0] st, logic [ValW-1:0] val, logic [CountW-1:0] cnt,
                    logic lst);
      list_word_t exp_w;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word: status %0d value %h count %0d last %0b",
                                  st, val, cnt, lst));
        return;
      end
      exp_w = owed_q.pop_front();
      checked++;
      status_tally[exp_w.status]++;
      if (st !== exp_w.status)
        report_mismatch($sformatf("status %0d, wanted %0d", st, exp_w.status));
      if (val !== exp_w.value)
        report_mismatch($sformatf("entry value %h, wanted %h", val, exp_w.value));
      if (cnt !== exp_w.count)
        report_mismatch($sformatf("entry count %0d, wanted %0d", cnt, exp_w.count));
      if (lst !== exp_w.last)
        report_mismatch($sformatf("tlast %0b, wanted %0b", lst, exp_w.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_valid;
  logic [39:0] s_tdata;   // position[7:0], value[39:8]
  logic [1:0]  s_kind;    // kind[1:0]
  logic        m_ready;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;  // entry_value[31:0], entry_count[36:32], zero[39:37]
  logic [1:0]  m_axis_tuser_o;  // status[1:0]
  logic        m_axis_tlast_o;

  list_scoreboard sb = new(Capacity);

  // Sender and receiver pacing controls
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  int unsigned rx_hold = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned directed_items = 0;

  positional_list_insert_delete_core #(
    .CAPACITY(Capacity)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_kind),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL positional_list_insert_delete_core");
    $finish;
  end

  // Monitor: check the output word first, then book the accepted input word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready)
        sb.check_word(m_axis_tuser_o, m_axis_tdata_o[31:0], m_axis_tdata_o[36:32],
                      m_axis_tlast_o);
      if (s_valid && s_axis_tready_o) sb.note_item(s_kind, s_tdata[7:0], s_tdata[39:8]);
    end
  end

  // Receiver: alternating ready and stall runs, or always ready with stalls off, a counted hold-off on request
  initial begin : rx_side
    int unsigned run_left;
    bit stalling;
    run_left = 0;
    stalling = 1'b0;
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_ready <= 1'b0;
        rx_hold--;
      end else if (!rx_stalls) begin
        m_ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          run_left = stalling ? $urandom_range(1, 5) : $urandom_range(1, 10);
        end
        run_left--;
        m_ready <= !stalling;
      end
    end
  end

  // Step to the next falling edge; between bursts, with gaps enabled, drop valid for a random gap
  task automatic next_slot();
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = tx_gaps ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Present one word at the current falling edge and hold it until taken
  task automatic offer(input logic [1:0] k, input logic [7:0] p, input logic [31:0] v);
    s_valid <= 1'b1;
    s_kind  <= k;
    s_tdata <= {v, p};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic send(input logic [1:0] k, input logic [7:0] p, input logic [31:0] v);
    next_slot();
    offer(k, p, v);
  endtask

  // Stop offering and wait until every owed word has come out
  task automatic drain();
    @(negedge clk_i);
    s_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Random item biased by the mix; a few raw items of any kind and position
  function automatic void pick(input mix_e mix, output logic [1:0] k, output logic [7:0] p,
                               output logic [31:0] v);
    int unsigned n, r, ins_pct, del_pct;
    n = sb.size();
    r = $urandom_range(0, 99);
    v = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = '0;
        default: v = '1;
      endcase
    end
    case (mix)
      ModeGrow:   begin ins_pct = 78; del_pct = 8;  end
      ModeShrink: begin ins_pct = 10; del_pct = 76; end
      default:    begin ins_pct = 40; del_pct = 40; end
    endcase
    if (r < 7) begin
      k = 2'($urandom_range(0, 3));
      p = 8'($urandom_range(0, 255));
    end else if (r < 7 + ins_pct) begin
      k = KindIns;
      p = 8'($urandom_range(1, n + 1));
    end else if (r < 7 + ins_pct + del_pct) begin
      k = KindDel;
      p = (n == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, n));
    end else begin
      k = KindDump;
      p = 8'($urandom_range(0, 255));
    end
  endfunction

  // A grow mix runs past its length until the whole run has seen two inserts bounce off a full list
  task automatic run_segment(input mix_e mix, input int unsigned len);
    logic [1:0]  k;
    logic [7:0]  p;
    logic [31:0] v;
    int unsigned done;
    done = 0;
    while (done < len || (mix == ModeGrow && sb.full_hits < 2)) begin
      next_slot();
      pick(mix, k, p, v);
      offer(k, p, v);
      done++;
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    s_valid = 1'b0;
    s_kind  = '0;
    s_tdata = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty list, range limits, front/middle/end inserts, spare kind, deletes
    send(KindDump,  8'd0,   32'h0);
    send(KindDel,   8'd1,   32'h0);
    send(KindDel,   8'd255, 32'h0);
    send(KindIns,   8'd0,   32'h5);
    send(KindIns,   8'd2,   32'h6);
    send(KindIns,   8'd255, 32'h7);
    send(KindIns,   8'd1,   32'h7FFF_FFFF);
    send(KindIns,   8'd1,   32'h8000_0000);
    send(KindIns,   8'd3,   32'hFFFF_FFFF);
    send(KindIns,   8'd2,   32'h0);
    send(KindDump,  8'd255, 32'hFFFF_FFFF);
    send(KindSpare, 8'd255, 32'hFFFF_FFFF);
    send(KindSpare, 8'd0,   32'h0);
    send(KindDel,   8'd0,   32'h0);
    send(KindDel,   8'd5,   32'h0);
    send(KindDel,   8'd2,   32'hAAAA_5555);
    send(KindDel,   8'd3,   32'h0);
    send(KindDump,  8'd0,   32'h0);
    send(KindDel,   8'd1,   32'h0);
    send(KindDel,   8'd1,   32'h0);
    send(KindDump,  8'd1,   32'h0);
    directed_items = items_sent;
    drain();

    // Random mixes: fill up, churn, empty out, refill under a long output stall, churn without gaps or stalls
    run_segment(ModeGrow, 30);
    drain();
    run_segment(ModeMixed, 25);
    run_segment(ModeShrink, 30);
    drain();
    rx_hold = 300;
    run_segment(ModeGrow, 25);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    run_segment(ModeMixed, 25);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    run_segment(ModeMixed, 15);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d items (%0d directed) and %0d result words; peak fill %0d of %0d.",
             items_sent, directed_items, sb.checked, sb.peak_fill, Capacity);
    $display("Words by status ok/range/full/empty: %0d/%0d/%0d/%0d; non-empty dumps: %0d.",
             sb.status_tally[StatOk], sb.status_tally[StatRange], sb.status_tally[StatFull],
             sb.status_tally[StatEmpty], sb.dumps);
    if (sb.errors == 0) begin
      $display("PASS positional_list_insert_delete_core");
    end else begin
      $display("FAIL positional_list_insert_delete_core");
    end
    $finish;
  end

endmodule

### files.f
design/pli_pkg.sv
design/pli_cell.sv
design/positional_list_insert_delete_core.sv
tb/sv/tb_positional_list_insert_delete_core.sv
